@@ rtl/mfd_pkg.sv @@
// Shared types and constants for the motor feedback decoder.
package mfd_pkg;

  // Encoder counts per mechanical turn; the step is unwrapped within half of this.
  localparam int ENC_COUNTS = 8192;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 42;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // APB address width: six 32-bit registers.
  localparam int PADDR_W = 5;

  typedef struct packed {
    logic        rev;
    logic [31:0] vel_gain;
    logic [31:0] cur_gain;
    logic [31:0] ang_gain;
    logic [16:0] alpha;
    logic [15:0] start_enc;
    logic        start_wr;
  } cfg_t;

endpackage

@@ rtl/mfd_if.sv @@
// Valid/ready channel interfaces for feedback frames and decoded results.
interface mfd_fb_if;
  logic       valid;
  logic       ready;
  logic [7:0] angle_high;
  logic [7:0] angle_low;
  logic [7:0] speed_high;
  logic [7:0] speed_low;
  logic [7:0] current_high;
  logic [7:0] current_low;
  logic [7:0] temperature_byte;

  modport source (
    output valid, angle_high, angle_low, speed_high, speed_low,
           current_high, current_low, temperature_byte,
    input  ready
  );
  modport sink (
    input  valid, angle_high, angle_low, speed_high, speed_low,
           current_high, current_low, temperature_byte,
    output ready
  );
endinterface

interface mfd_res_if;
  logic               valid;
  logic               ready;
  logic        [15:0] encoder_raw;
  logic signed [47:0] angle_total;
  logic signed [39:0] velocity_unfiltered;
  logic signed [39:0] velocity_smoothed;
  logic signed [31:0] current_amps;
  logic        [7:0]  temperature_out;
  logic               link_ok;

  modport source (
    output valid, encoder_raw, angle_total, velocity_unfiltered, velocity_smoothed,
           current_amps, temperature_out, link_ok,
    input  ready
  );
  modport sink (
    input  valid, encoder_raw, angle_total, velocity_unfiltered, velocity_smoothed,
           current_amps, temperature_out, link_ok,
    output ready
  );
endinterface

@@ rtl/mfd_apb_regs.sv @@
// APB configuration register file for the motor feedback decoder.
module mfd_apb_regs import mfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  localparam logic [2:0] REG_REVERSE   = 3'd0;
  localparam logic [2:0] REG_VEL_GAIN  = 3'd1;
  localparam logic [2:0] REG_CUR_GAIN  = 3'd2;
  localparam logic [2:0] REG_ANG_GAIN  = 3'd3;
  localparam logic [2:0] REG_ALPHA     = 3'd4;
  localparam logic [2:0] REG_START_ENC = 3'd5;

  logic [2:0]  reg_idx;
  logic        wr;
  logic        rev;
  logic [31:0] vel_gain;
  logic [31:0] cur_gain;
  logic [31:0] ang_gain;
  logic [16:0] alpha;
  logic [15:0] start_enc;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rev       <= 1'b0;
      vel_gain  <= 32'd100663296;
      cur_gain  <= 32'd20480;
      ang_gain  <= 32'd737280;
      alpha     <= 17'd6554;
      start_enc <= 16'd0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_REVERSE:   rev       <= pwdata[0];
        REG_VEL_GAIN:  vel_gain  <= pwdata;
        REG_CUR_GAIN:  cur_gain  <= pwdata;
        REG_ANG_GAIN:  ang_gain  <= pwdata;
        REG_ALPHA:     alpha     <= pwdata[16:0];
        REG_START_ENC: start_enc <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_REVERSE:   prdata = {31'd0, rev};
      REG_VEL_GAIN:  prdata = vel_gain;
      REG_CUR_GAIN:  prdata = cur_gain;
      REG_ANG_GAIN:  prdata = ang_gain;
      REG_ALPHA:     prdata = {15'd0, alpha};
      REG_START_ENC: prdata = {16'd0, start_enc};
      default:       prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.rev       = rev;
    cfg.vel_gain  = vel_gain;
    cfg.cur_gain  = cur_gain;
    cfg.ang_gain  = ang_gain;
    cfg.alpha     = alpha;
    cfg.start_enc = pwdata[15:0];
    // pulse on a start encoder write; carries the value being written
    cfg.start_wr  = wr && (reg_idx == REG_START_ENC);
  end

endmodule

@@ rtl/mfd_mul.sv @@
// Shared signed multiplier with registered product.
module mfd_mul import mfd_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  product
);

  always_ff @(posedge clk) begin
    if (en) begin
      product <= a * b;
    end
  end

endmodule

@@ rtl/motor_feedback_decode_core.sv @@
// Motor feedback decoder: scaling, encoder unwrap, saturating angle and low-pass velocity.
// A frame accepted in S_IDLE steps through S_MUL_VEL, S_MUL_CUR, S_MUL_ANG, S_MUL_FLT and S_FILT to its result.
// A new frame is taken only in S_IDLE; the single shared multiplier is used four times a frame.
// A result waiting in the output register does not block the next frame until its last step.
// Reset (rst, synchronous): registers to defaults, angle and filter cleared, no result pending.
module motor_feedback_decode_core import mfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  mfd_fb_if.sink             feedback,
  mfd_res_if.source          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_VEL,
    S_MUL_CUR,
    S_MUL_ANG,
    S_MUL_FLT,
    S_FILT
  } state_t;

  localparam logic signed [16:0] ENC_HALF = 17'(ENC_COUNTS / 2);
  localparam logic signed [16:0] ENC_FULL = 17'(ENC_COUNTS);
  localparam logic        [16:0] ALPHA_ONE = 17'd65536;

  cfg_t cfg;

  state_t             state;
  logic        [15:0] enc_r;
  logic signed [15:0] speed_r;
  logic signed [15:0] curr_r;
  logic        [7:0]  temp_r;
  logic signed [16:0] err_r;
  logic signed [39:0] vel_r;
  logic signed [31:0] amp_r;
  logic signed [41:0] diff_r;
  logic signed [47:0] acc;
  logic signed [39:0] vf;
  logic        [15:0] prev_enc;
  logic               link_valid;
  logic               out_valid;

  logic        [15:0] out_enc;
  logic signed [47:0] out_acc;
  logic signed [39:0] out_vel;
  logic signed [39:0] out_vf;
  logic signed [31:0] out_amp;
  logic        [7:0]  out_temp;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic        [16:0] alpha_eff;
  logic        [15:0] err_raw;
  logic signed [16:0] err_next;
  logic signed [41:0] scaled;
  logic signed [48:0] acc_sum;
  logic signed [PROD_W-1:0] flt_round;
  logic signed [41:0] flt_step;
  logic signed [42:0] vf_sum;
  logic signed [39:0] vf_next;

  // Q.24 product to Q.16, round half up, optional negate
  function automatic logic signed [41:0] q24_to_q16(input logic signed [PROD_W-1:0] p,
                                                    input logic rev);
    logic signed [PROD_W-1:0] r;
    logic signed [41:0] s;
    r = (p + PROD_W'(128)) >>> 8;
    s = r[41:0];
    return rev ? -s : s;
  endfunction

  function automatic logic signed [39:0] sat_40(input logic signed [42:0] x);
    if ((&x[42:39]) || !(|x[42:39])) begin
      return x[39:0];
    end
    return x[42] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [41:0] x);
    if ((&x[41:31]) || !(|x[41:31])) begin
      return x[31:0];
    end
    return x[41] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic signed [47:0] sat_48(input logic signed [48:0] x);
    if (x[48] == x[47]) begin
      return x[47:0];
    end
    return x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  mfd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mfd_mul u_mul (
    .clk     (clk),
    .en      (mul_en),
    .a       (mul_a),
    .b       (mul_b),
    .product (prod)
  );

  assign alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;

  // shortest-path encoder step
  assign err_raw = enc_r - prev_enc;
  always_comb begin
    err_next = {err_raw[15], err_raw};
    if (err_next > ENC_HALF) begin
      err_next = err_next - ENC_FULL;
    end else if (err_next < -ENC_HALF) begin
      err_next = err_next + ENC_FULL;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      S_MUL_VEL: begin
        mul_a = {{(MUL_A_W-16){speed_r[15]}}, speed_r};
        mul_b = {{(MUL_B_W-32){1'b0}}, cfg.vel_gain};
      end
      S_MUL_CUR: begin
        mul_a = {{(MUL_A_W-16){curr_r[15]}}, curr_r};
        mul_b = {{(MUL_B_W-32){1'b0}}, cfg.cur_gain};
      end
      S_MUL_ANG: begin
        mul_a = {{(MUL_A_W-17){err_r[16]}}, err_r};
        mul_b = {{(MUL_B_W-32){1'b0}}, cfg.ang_gain};
      end
      S_MUL_FLT: begin
        mul_a = {{(MUL_A_W-17){1'b0}}, alpha_eff};
        mul_b = diff_r;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign scaled    = q24_to_q16(prod, cfg.rev);
  assign acc_sum   = {acc[47], acc} + {{7{scaled[41]}}, scaled};
  assign flt_round = (prod + PROD_W'(32768)) >>> 16;
  assign flt_step  = flt_round[41:0];
  assign vf_sum    = {{3{vf[39]}}, vf} + {flt_step[41], flt_step};
  assign vf_next   = sat_40(vf_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      acc        <= '0;
      vf         <= '0;
      prev_enc   <= '0;
      link_valid <= 1'b0;
    end else begin
      if (cfg.start_wr && !link_valid) begin
        prev_enc <= cfg.start_enc;
      end
      // in S_FILT a drained result is replaced by the new one below
      if (out_valid && result.ready && (state != S_FILT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (feedback.valid) begin
            enc_r   <= {feedback.angle_high, feedback.angle_low};
            speed_r <= {feedback.speed_high, feedback.speed_low};
            curr_r  <= {feedback.current_high, feedback.current_low};
            temp_r  <= feedback.temperature_byte;
            state   <= S_MUL_VEL;
          end
        end
        S_MUL_VEL: begin
          err_r <= err_next;
          state <= S_MUL_CUR;
        end
        S_MUL_CUR: begin
          vel_r <= sat_40({scaled[41], scaled});
          state <= S_MUL_ANG;
        end
        S_MUL_ANG: begin
          amp_r  <= sat_32(scaled);
          diff_r <= {{2{vel_r[39]}}, vel_r} - {{2{vf[39]}}, vf};
          state  <= S_MUL_FLT;
        end
        S_MUL_FLT: begin
          acc   <= sat_48(acc_sum);
          state <= S_FILT;
        end
        S_FILT: begin
          // hold here while the previous result is still unread
          if (!out_valid || result.ready) begin
            vf         <= vf_next;
            out_enc    <= enc_r;
            out_acc    <= acc;
            out_vel    <= vel_r;
            out_vf     <= vf_next;
            out_amp    <= amp_r;
            out_temp   <= temp_r;
            out_valid  <= 1'b1;
            prev_enc   <= enc_r;
            link_valid <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign feedback.ready             = (state == S_IDLE);
  assign result.valid               = out_valid;
  assign result.encoder_raw         = out_enc;
  assign result.angle_total         = out_acc;
  assign result.velocity_unfiltered = out_vel;
  assign result.velocity_smoothed   = out_vf;
  assign result.current_amps        = out_amp;
  assign result.temperature_out     = out_temp;
  assign result.link_ok             = link_valid;

endmodule
